[sv/rcr_pkg.sv]
`default_nettype none

package rcr_pkg;

    localparam int CFG_W        = 10;
    localparam int MAX_SIDE_DEF = 512;
    localparam int COORD_W      = 23;

    localparam logic [7:0] BG_RESET     = 8'd32;
    localparam logic [7:0] KIND_FILLED  = 8'h52;
    localparam logic [7:0] KIND_OUTLINE = 8'h72;

    localparam logic signed [COORD_W-1:0] FRAC_ONE = COORD_W'(256);

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_DRAW  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BG     = 2'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [19:0] rect_x;
        logic signed [19:0] rect_y;
        logic signed [19:0] rect_w;
        logic signed [19:0] rect_h;
        logic [7:0]         kind_char;
        logic [7:0]         fill_char;
        logic [8:0]         pixel_col;
        logic [8:0]         pixel_row;
    } t_in_item;

    typedef struct packed {
        logic       status;
        logic [7:0] pixel_char;
    } t_out_item;

    typedef struct packed {
        logic                      clear;
        logic                      outline;
        logic [7:0]                data;
        logic signed [COORD_W-1:0] x_lo;
        logic signed [COORD_W-1:0] x_hi;
        logic signed [COORD_W-1:0] x_in;
        logic signed [COORD_W-1:0] x_out;
        logic signed [COORD_W-1:0] y_lo;
        logic signed [COORD_W-1:0] y_hi;
        logic signed [COORD_W-1:0] y_in;
        logic signed [COORD_W-1:0] y_out;
    } t_sweep_cmd;

    typedef struct packed {
        logic wr_en;
        logic last;
    } t_sweep_stat;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_READ,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

[sv/rcr_canvas_mem.sv]
`default_nettype none

module rcr_canvas_mem
    import rcr_pkg::*;
#(
    parameter int ADDR_W = 18
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [7:0]        i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic [7:0]             o_rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[sv/rcr_sweep.sv]
`default_nettype none

module rcr_sweep
    import rcr_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire t_sweep_cmd               i_cmd,
    input  wire logic [$clog2(MAX_SIDE+1)-1:0] i_wd,
    input  wire logic [$clog2(MAX_SIDE+1)-1:0] i_ht,
    output t_sweep_stat                   o_stat,
    output logic [2*((MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1)-1:0] o_addr,
    output logic [7:0]                    o_wdata
);

    localparam int CW = $clog2(MAX_SIDE + 1);
    localparam int AW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

    logic          r_active;
    t_sweep_cmd    r_cmd;
    logic [AW-1:0] r_row;
    logic [AW-1:0] r_col;
    logic [AW-1:0] r_last_col;
    logic [AW-1:0] r_last_row;

    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic inx;
    logic iny;
    logic edgex;
    logic edgey;
    logic paint;
    logic end_col;
    logic end_row;

    always_comb begin
        px      = $signed(COORD_W'({r_col, 8'd0}));
        py      = $signed(COORD_W'({r_row, 8'd0}));
        inx     = (r_cmd.x_lo <= px) && (px <= r_cmd.x_hi);
        iny     = (r_cmd.y_lo <= py) && (py <= r_cmd.y_hi);
        edgex   = (px < r_cmd.x_in) || (px > r_cmd.x_out);
        edgey   = (py < r_cmd.y_in) || (py > r_cmd.y_out);
        paint   = r_cmd.clear || (inx && iny && (!r_cmd.outline || edgex || edgey));
        end_col = (r_col == r_last_col);
        end_row = (r_row == r_last_row);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_start) begin
            r_active <= 1'b1;
        end else if (r_active && end_col && end_row) begin
            r_active <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cmd      <= i_cmd;
            r_row      <= '0;
            r_col      <= '0;
            r_last_col <= AW'(i_wd - CW'(1));
            r_last_row <= AW'(i_ht - CW'(1));
        end else if (r_active) begin
            if (end_col) begin
                r_col <= '0;
                r_row <= r_row + AW'(1);
            end else begin
                r_col <= r_col + AW'(1);
            end
        end
    end

    always_comb begin
        o_stat.wr_en  = r_active && paint;
        o_stat.last   = r_active && end_col && end_row;
        o_addr        = {r_row, r_col};
        o_wdata       = r_cmd.data;
    end

endmodule

`default_nettype wire

[sv/rectangle_canvas_rasterizer_core.sv]
// Rectangle rasterizer on a byte canvas held in one synchronous memory.
// Input channel: i_valid / o_stall carry one item per beat (clear, draw or
// read). Output channel: o_valid / i_stall carry exactly one result per item.
// Configuration: i_cfg_we writes canvas width, height or background byte at
// index 0, 1 or 2; write only while no item is in flight.
// A clear or accepted draw walks every in-use pixel once, up to MAX_SIDE
// squared, one pixel per cycle, writing each pixel that it paints. A read
// passes three steps: the memory read, the capture of its registered data
// and the load of the output register. A rejected draw, an out-of-range
// read or an unused opcode goes straight to the load of its result.
// The block works on one item at a time; o_stall is high from acceptance
// until the result moves into the output register. That register holds a
// result while i_stall is high, and a new item may be taken meanwhile.
// Reset clears control state and the registers to width 1, height 1 and
// background 0x20. The canvas is not cleared by reset; issue a clear before
// reading any pixel.
`default_nettype none

module rectangle_canvas_rasterizer_core
    import rcr_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire t_in_item         i_item,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output t_out_item             o_item,
    input  wire logic             i_cfg_we,
    input  wire logic [1:0]       i_cfg_index,
    input  wire logic [CFG_W-1:0] i_cfg_wdata
);

    localparam int CW = $clog2(MAX_SIDE + 1);
    localparam int AW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int RW = (CW > 9) ? CW : 9;

    t_state           r_state;
    t_state           n_state;
    logic [CFG_W-1:0] r_cfg_w;
    logic [CFG_W-1:0] r_cfg_h;
    logic [7:0]       r_bg;
    t_out_item        r_res;
    t_out_item        n_res;
    t_out_item        r_out;
    t_out_item        n_out;
    logic             r_out_valid;
    logic             n_out_valid;

    logic [CW-1:0]     wd;
    logic [CW-1:0]     ht;
    logic              sweep_start;
    t_sweep_cmd        cmd;
    t_sweep_stat       sw_stat;
    logic [2*AW-1:0]   sw_addr;
    logic [7:0]        sw_data;
    logic              rd_en;
    logic [2*AW-1:0]   rd_addr;
    logic [7:0]        rd_data;
    logic              in_range;
    logic              reject;
    logic signed [COORD_W-1:0] x0;
    logic signed [COORD_W-1:0] y0;
    logic signed [COORD_W-1:0] w0;
    logic signed [COORD_W-1:0] h0;

    function automatic logic [CW-1:0] clamp_side(input logic [CFG_W-1:0] v);
        logic [CW-1:0] res;
        if (v == '0) begin
            res = CW'(1);
        end else if (int'(v) > MAX_SIDE) begin
            res = CW'(MAX_SIDE);
        end else begin
            res = CW'(v);
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= CFG_W'(1);
            r_cfg_h <= CFG_W'(1);
            r_bg    <= BG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_WIDTH: begin
                    r_cfg_w <= i_cfg_wdata;
                end
                REG_HEIGHT: begin
                    r_cfg_h <= i_cfg_wdata;
                end
                REG_BG: begin
                    r_bg <= i_cfg_wdata[7:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        wd = clamp_side(r_cfg_w);
        ht = clamp_side(r_cfg_h);
        x0 = COORD_W'(i_item.rect_x);
        y0 = COORD_W'(i_item.rect_y);
        w0 = COORD_W'(i_item.rect_w);
        h0 = COORD_W'(i_item.rect_h);

        cmd.clear   = (i_item.opcode == OP_CLEAR);
        cmd.outline = (i_item.kind_char == KIND_OUTLINE);
        cmd.data    = cmd.clear ? r_bg : i_item.fill_char;
        cmd.x_lo    = x0;
        cmd.x_hi    = x0 + w0;
        cmd.x_in    = x0 + FRAC_ONE;
        cmd.x_out   = x0 + w0 - FRAC_ONE;
        cmd.y_lo    = y0;
        cmd.y_hi    = y0 + h0;
        cmd.y_in    = y0 + FRAC_ONE;
        cmd.y_out   = y0 + h0 - FRAC_ONE;

        reject = (i_item.rect_w <= 20'sd0) || (i_item.rect_h <= 20'sd0)
               || !((i_item.kind_char == KIND_FILLED)
                    || (i_item.kind_char == KIND_OUTLINE));
        in_range = (RW'(i_item.pixel_col) < RW'(wd)) && (RW'(i_item.pixel_row) < RW'(ht));
        rd_addr  = {AW'(RW'(i_item.pixel_row)), AW'(RW'(i_item.pixel_col))};
    end

    always_comb begin
        n_state     = r_state;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_stall;
        sweep_start = 1'b0;
        rd_en       = 1'b0;
        o_stall     = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_res = '0;
                    case (i_item.opcode)
                        OP_CLEAR: begin
                            sweep_start = 1'b1;
                            n_state     = ST_SWEEP;
                        end
                        OP_DRAW: begin
                            if (reject) begin
                                n_res.status = 1'b1;
                                n_state      = ST_DONE;
                            end else begin
                                sweep_start = 1'b1;
                                n_state     = ST_SWEEP;
                            end
                        end
                        OP_READ: begin
                            if (in_range) begin
                                rd_en   = 1'b1;
                                n_state = ST_READ;
                            end else begin
                                n_state = ST_DONE;
                            end
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SWEEP: begin
                if (sw_stat.last) begin
                    n_state = ST_DONE;
                end
            end
            ST_READ: begin
                n_res.pixel_char = rd_data;
                n_state          = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_out <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    rcr_sweep #(
        .MAX_SIDE (MAX_SIDE)
    ) u_sweep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sweep_start),
        .i_cmd   (cmd),
        .i_wd    (wd),
        .i_ht    (ht),
        .o_stat  (sw_stat),
        .o_addr  (sw_addr),
        .o_wdata (sw_data)
    );

    rcr_canvas_mem #(
        .ADDR_W (2 * AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (sw_stat.wr_en),
        .i_waddr (sw_addr),
        .i_wdata (sw_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

endmodule

`default_nettype wire

[sv/rcr_checker.sv]
`default_nettype none

module rcr_checker
    import rcr_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_valid,
    input wire logic      o_stall,
    input wire logic      o_valid,
    input wire logic      i_stall,
    input wire t_out_item o_item
);

    // The block works on one item at a time, so an accepted beat closes the input.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input accepted while an item was still in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_item)))
        else $error("stalled output beat changed");

    // A new result is only loaded at the end of an item's work.
    a_result_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared with no item in work");

    a_reject_no_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.status) |-> (o_item.pixel_char == 8'd0))
        else $error("rejected draw carries a pixel byte");

endmodule

bind rectangle_canvas_rasterizer_core rcr_checker u_rcr_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_item  (o_item)
);

`default_nettype wire
